>>> hw/rtl/dos_pkg.sv
// Shared types, widths and codes for the delayed output scheduler.
`default_nettype none

package dos_pkg;

	localparam int CNT_W     = 32;
	localparam int DELAY_W   = 32;
	localparam int PERIOD_W  = 8;
	localparam int CH_W      = 2;
	localparam int NUM_CH    = 2;
	localparam int IDX_W     = 2;
	localparam int IN_W      = 40;
	localparam int OUT_W     = 8;
	localparam int STEP_W    = $clog2(DELAY_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DELAY_W - 1);

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_REQ  = 1'b1;

	localparam logic [IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_DELAY   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN_DELAY   = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

	typedef struct packed {
		logic capture;
		logic div_step;
		logic finish;
		logic arm;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic is_ignored;
		logic below_min;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/dos_ctrl.sv
// Sequencer for item capture, serial division and result write-back.
`default_nettype none

module dos_ctrl import dos_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      ctl
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t              state_q, state_n;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic                accept;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.capture = 1'b1;
					state_n     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_tick || sts.is_ignored || sts.below_min) begin
					ctl.finish = 1'b1;
					state_n    = ST_IDLE;
				end else begin
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (step_q == LAST_STEP) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				ctl.finish = 1'b1;
				ctl.arm    = 1'b1;
				state_n    = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost its one-hot code");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !out_valid_q)
		else $error("result written while output register still full");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> out_valid_q)
		else $error("finished item produced no result transfer");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == LAST_STEP) |=> state_q == ST_FIN)
		else $error("division did not end after its last step");

endmodule

`default_nettype wire

>>> hw/rtl/dos_dp.sv
// Datapath: config registers, channel state, serial divider and result register.
`default_nettype none

module dos_dp import dos_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [31:0]      cfg_data,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             s_tuser,
	input  wire dp_cmd_t          ctl,
	output dp_sts_t               sts,
	output logic [OUT_W-1:0]      m_tdata
);

	logic [PERIOD_W-1:0]            period_q;
	logic [DELAY_W-1:0]             max_q;
	logic [DELAY_W-1:0]             min_q;

	logic [CNT_W-1:0]               count_q;
	logic [NUM_CH-1:0][CNT_W-1:0]   cmp_q;
	logic [NUM_CH-1:0]              armed_q;
	logic [NUM_CH-1:0]              pend_q;
	logic [NUM_CH-1:0]              drive_q;

	logic                           cmd_q;
	logic [CH_W-1:0]                ch_q;
	logic                           lvl_q;
	logic                           clip_q;
	logic [DELAY_W-1:0]             quo_q;
	logic [PERIOD_W-1:0]            rem_q;
	logic [OUT_W-1:0]               out_q;

	logic [DELAY_W-1:0]             in_delay;
	logic                           in_clip;
	logic [PERIOD_W-1:0]            divisor;
	logic [PERIOD_W:0]              trial;
	logic                           fits;

	logic [CNT_W-1:0]               cnt_n;
	logic [NUM_CH-1:0][CNT_W-1:0]   cmp_n;
	logic [NUM_CH-1:0]              armed_n;
	logic [NUM_CH-1:0]              pend_n;
	logic [NUM_CH-1:0]              drive_n;
	logic [NUM_CH-1:0]              fired;
	logic                           clipped_out;

	assign in_delay = s_tdata[34:3];
	assign in_clip  = in_delay > max_q;

	// one restoring step per cycle; a period of zero divides by one
	assign divisor = (period_q == '0) ? PERIOD_RESET : period_q;
	assign trial   = {rem_q, quo_q[DELAY_W-1]};
	assign fits    = trial >= {1'b0, divisor};

	assign sts.is_tick    = (cmd_q == CMD_TICK);
	assign sts.is_ignored = ch_q[1];
	assign sts.below_min  = quo_q < min_q;

	assign clipped_out = (cmd_q == CMD_REQ) && !ch_q[1] && clip_q;

	always_comb begin
		cnt_n   = count_q;
		cmp_n   = cmp_q;
		armed_n = armed_q;
		pend_n  = pend_q;
		drive_n = drive_q;
		fired   = '0;
		if (cmd_q == CMD_TICK) begin
			cnt_n = count_q + CNT_W'(1);
			for (int i = 0; i < NUM_CH; i++) begin
				if (armed_q[i] && cmp_q[i] == cnt_n) begin
					drive_n[i] = pend_q[i];
					armed_n[i] = 1'b0;
					cmp_n[i]   = '1;
					fired[i]   = 1'b1;
				end
			end
		end else if (!ch_q[1]) begin
			if (ctl.arm) begin
				pend_n[ch_q[0]]  = lvl_q;
				cmp_n[ch_q[0]]   = count_q + CNT_W'(quo_q);
				armed_n[ch_q[0]] = 1'b1;
			end else begin
				drive_n[ch_q[0]] = lvl_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			max_q    <= '1;
			min_q    <= '0;
			count_q  <= '0;
			cmp_q    <= '1;
			armed_q  <= '0;
			pend_q   <= '0;
			drive_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TICK_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
					REG_MAX_DELAY:   max_q    <= cfg_data[DELAY_W-1:0];
					REG_MIN_DELAY:   min_q    <= cfg_data[DELAY_W-1:0];
					default: ;
				endcase
			end
			if (ctl.finish) begin
				count_q <= cnt_n;
				cmp_q   <= cmp_n;
				armed_q <= armed_n;
				pend_q  <= pend_n;
				drive_q <= drive_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= s_tuser;
			ch_q   <= s_tdata[1:0];
			lvl_q  <= s_tdata[2];
			clip_q <= in_clip;
			quo_q  <= in_clip ? max_q : in_delay;
			rem_q  <= '0;
		end else if (ctl.div_step) begin
			rem_q <= fits ? PERIOD_W'(trial - {1'b0, divisor}) : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[DELAY_W-2:0], fits};
		end
		if (ctl.finish) begin
			out_q <= {sts.is_ignored && (cmd_q == CMD_REQ), clipped_out,
				armed_n, fired, drive_n};
		end
	end

	assign m_tdata = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/delayed_output_scheduler.sv
// Sequence: a tick, an ignored request or an immediate-drive request passes through capture,
// decode and write; a request that arms a channel passes through capture, decode, 32 divide steps
// and write. Items are handled one at a time; the serial delay divider bounds requests.
// Back-pressure: take the next item once the sequencer is idle and the result register is empty
// or its result transfers in that same cycle.
// Reset: arst_n asynchronously clears counter, arm flags and levels, presets compares to all
// ones and loads the register defaults (tick period 1, max all ones, min 0).
`default_nettype none

module delayed_output_scheduler import dos_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration write channel, always ready
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [31:0]      cfg_data,
	// input stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // channel[1:0], target_level[2], delay[34:3], zero pad
	input  wire logic             s_tuser,  // cmd[0]: tick or schedule request
	// result stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata   // level_mask[1:0], fired_mask[3:2], armed_mask[5:4],
	                                        // delay_clipped[6], request_ignored[7]
);

	dp_cmd_t ctl;
	dp_sts_t sts;

	// every register write lands as it arrives, so never hold the channel
	assign cfg_ready = 1'b1;

	// sequence each transfer: capture, decide, divide if arming, write back
	dos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// hold config, counter and channel state; divide the clipped delay by the tick period
	dos_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.ctl       (ctl),
		.sts       (sts),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
